// ===== rtl/hcbp_pkg.sv =====
// Shared widths, function codes and control structs of the prefix-code bit packer.
`default_nettype none

package hcbp_pkg;

  // Field widths of one input item and one result item
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned SYM_W  = 8;
  localparam int unsigned CODE_W = 32;
  localparam int unsigned LEN_W  = 6;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned HELD_W = 3;
  localparam int unsigned PAD_W  = 3;
  localparam int unsigned NEED_W = 4;

  // Packed stream widths
  localparam int unsigned IN_TDATA_W   = 48;
  localparam int unsigned OUT_TDATA_W  = 16;
  localparam int unsigned OUT_TUSER_W  = 2;

  // Parameter defaults
  localparam int unsigned MAX_CODE_LEN_DEF = 32;
  localparam int unsigned SYMBOL_COUNT_DEF = 256;

  // Function codes carried on the input tuser
  localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ENCODE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FLUSH  = 2'd2;

  // Commands from the controller
  typedef struct packed {
    logic tbl_load;    // write the code table entry of the input item
    logic tbl_read;    // read the code table entry of the input item
    logic pend_load;   // copy the table read data into the pending code
    logic pack_step;   // emit one byte or merge the leftover bits
    logic flush_emit;  // emit the padded partial byte
    logic miss_emit;   // emit the missing-code result
  } ctrl_cmd_t;

  // Status from the packing datapath
  typedef struct packed {
    logic slot_free;       // output register can take a result this cycle
    logic rem_ge_need;     // pending bits complete a byte
    logic rem_after_zero;  // no bits remain after this byte
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/hcbp_table.sv =====
// Code table: left-aligned code bits and lengths in a memory, valid bits in flops.
`default_nettype none

module hcbp_table #(
  parameter int unsigned MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF,
  parameter int unsigned SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire hcbp_pkg::ctrl_cmd_t          cmd_i,
  input  wire logic [hcbp_pkg::SYM_W-1:0]   symbol_i,
  input  wire logic [hcbp_pkg::CODE_W-1:0]  code_value_i,
  input  wire logic [hcbp_pkg::LEN_W-1:0]   code_length_i,
  output logic                              hit_o,
  output logic [hcbp_pkg::CODE_W-1:0]       rd_code_o,
  output logic [hcbp_pkg::LEN_W-1:0]        rd_len_o
);
  import hcbp_pkg::*;

  localparam int unsigned IDX_W     = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int unsigned LEN_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int unsigned ENTRY_W   = CODE_W + LEN_W;
  localparam int unsigned SHAMT_W   = $clog2(CODE_W);

  logic [ENTRY_W-1:0]      mem_q [SYMBOL_COUNT];
  logic [ENTRY_W-1:0]      rd_q;
  logic [SYMBOL_COUNT-1:0] valid_q;
  logic [IDX_W-1:0]        idx;
  logic                    in_range;
  logic                    len_ok;
  logic                    wr_en;
  logic [LEN_W-1:0]        shamt;
  logic [CODE_W-1:0]       code_al;

  assign idx      = symbol_i[IDX_W-1:0];
  assign in_range = {1'b0, symbol_i} < (SYM_W + 1)'(SYMBOL_COUNT);
  assign len_ok   = (code_length_i != '0) && (code_length_i <= LEN_W'(LEN_LIMIT));
  assign wr_en    = cmd_i.tbl_load && in_range && len_ok;

  // Left-align the code so the first bit sits in the top bit; bits above the length drop out
  assign shamt   = LEN_W'(CODE_W) - code_length_i;
  assign code_al = code_value_i << shamt[SHAMT_W-1:0];

  assign hit_o = in_range && valid_q[idx];

  // Mark entries valid as they are loaded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en) begin
      valid_q[idx] <= 1'b1;
    end
  end

  // Write and read the entry memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[idx] <= {code_length_i, code_al};
    end
    if (cmd_i.tbl_read) begin
      rd_q <= mem_q[idx];
    end
  end

  assign rd_code_o = rd_q[CODE_W-1:0];
  assign rd_len_o  = rd_q[ENTRY_W-1:CODE_W];

endmodule

`default_nettype wire

// ===== rtl/hcbp_dp.sv =====
// Packing datapath: pending code, byte accumulator and the output register.
`default_nettype none

module hcbp_dp (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire hcbp_pkg::ctrl_cmd_t          cmd_i,
  input  wire logic [hcbp_pkg::CODE_W-1:0]  rd_code_i,
  input  wire logic [hcbp_pkg::LEN_W-1:0]   rd_len_i,
  output hcbp_pkg::dp_status_t              status_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [hcbp_pkg::BYTE_W-1:0]       data_byte_o,
  output logic                              byte_present_o,
  output logic [hcbp_pkg::PAD_W-1:0]        pad_count_o,
  output logic                              missing_code_o,
  output logic                              last_of_run_o
);
  import hcbp_pkg::*;

  logic [CODE_W-1:0] pend_q, pend_d;
  logic [LEN_W-1:0]  rem_q, rem_d;
  logic [BYTE_W-1:0] acc_q, acc_d;
  logic [HELD_W-1:0] held_q, held_d;

  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_byte_q, out_byte_d;
  logic              out_present_q, out_present_d;
  logic [PAD_W-1:0]  out_pad_q, out_pad_d;
  logic              out_miss_q, out_miss_d;
  logic              out_last_q, out_last_d;

  logic [NEED_W-1:0] need;
  logic [NEED_W-1:0] pad_w;
  logic [LEN_W-1:0]  rem_after;
  logic [BYTE_W-1:0] top8;
  logic [BYTE_W-1:0] full_byte;
  logic [BYTE_W-1:0] merged;
  logic              slot_free;
  logic              emit_byte;

  assign need      = NEED_W'(BYTE_W) - NEED_W'(held_q);
  assign pad_w     = NEED_W'(BYTE_W) - NEED_W'(held_q);
  assign rem_after = rem_q - LEN_W'(need);
  assign top8      = pend_q[CODE_W-1 -: BYTE_W];
  assign full_byte = BYTE_W'(acc_q << need) | (top8 >> held_q);
  assign merged    = BYTE_W'(acc_q << rem_q) | (top8 >> (NEED_W'(BYTE_W) - NEED_W'(rem_q)));
  assign slot_free = !out_valid_q || out_ready_i;

  assign status_o.slot_free      = slot_free;
  assign status_o.rem_ge_need    = rem_q >= LEN_W'(need);
  assign status_o.rem_after_zero = rem_after == '0;

  assign emit_byte = cmd_i.pack_step && status_o.rem_ge_need;

  // Advance the pending code and the accumulator
  always_comb begin
    pend_d = pend_q;
    rem_d  = rem_q;
    acc_d  = acc_q;
    held_d = held_q;
    if (cmd_i.pend_load) begin
      pend_d = rd_code_i;
      rem_d  = rd_len_i;
    end else if (emit_byte) begin
      pend_d = pend_q << need;
      rem_d  = rem_after;
      acc_d  = '0;
      held_d = '0;
    end else if (cmd_i.pack_step) begin
      // fewer bits than a byte needs: keep them in the accumulator
      acc_d  = merged;
      held_d = held_q + HELD_W'(rem_q);
      rem_d  = '0;
    end else if (cmd_i.flush_emit) begin
      acc_d  = '0;
      held_d = '0;
    end
  end

  // Load the output register, drop it once taken
  always_comb begin
    out_valid_d   = out_valid_q && !out_ready_i;
    out_byte_d    = out_byte_q;
    out_present_d = out_present_q;
    out_pad_d     = out_pad_q;
    out_miss_d    = out_miss_q;
    out_last_d    = out_last_q;
    if (emit_byte) begin
      out_valid_d   = 1'b1;
      out_byte_d    = full_byte;
      out_present_d = 1'b1;
      out_pad_d     = '0;
      out_miss_d    = 1'b0;
      out_last_d    = rem_after < LEN_W'(BYTE_W);
    end else if (cmd_i.flush_emit) begin
      out_valid_d   = 1'b1;
      out_present_d = held_q != '0;
      out_byte_d    = (held_q != '0) ? BYTE_W'(acc_q << pad_w) : '0;
      out_pad_d     = (held_q != '0) ? PAD_W'(pad_w) : '0;
      out_miss_d    = 1'b0;
      out_last_d    = 1'b1;
    end else if (cmd_i.miss_emit) begin
      out_valid_d   = 1'b1;
      out_byte_d    = '0;
      out_present_d = 1'b0;
      out_pad_d     = '0;
      out_miss_d    = 1'b1;
      out_last_d    = 1'b1;
    end
  end

  // Hold control and accumulator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      acc_q       <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rem_q       <= rem_d;
      acc_q       <= acc_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    pend_q        <= pend_d;
    out_byte_q    <= out_byte_d;
    out_present_q <= out_present_d;
    out_pad_q     <= out_pad_d;
    out_miss_q    <= out_miss_d;
    out_last_q    <= out_last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign data_byte_o    = out_byte_q;
  assign byte_present_o = out_present_q;
  assign pad_count_o    = out_pad_q;
  assign missing_code_o = out_miss_q;
  assign last_of_run_o  = out_last_q;

`ifndef SYNTHESIS
  // A result is only written when the output register has room
  a_emit_has_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_byte || cmd_i.flush_emit || cmd_i.miss_emit) |-> slot_free)
    else $error("result written into an occupied output register");

  // A flush leaves the accumulator empty
  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.flush_emit |=> (held_q == '0) && (acc_q == '0))
    else $error("accumulator not cleared by flush");

  // A merge never fills a whole byte
  a_merge_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.pack_step && !status_o.rem_ge_need) |-> (LEN_W'(held_q) + rem_q) < LEN_W'(BYTE_W))
    else $error("merge overflows the accumulator");
`endif

endmodule

`default_nettype wire

// ===== rtl/hcbp_ctrl.sv =====
// Controller: decodes each input item and sequences table load, lookup, byte emission, missing-code result and flush.
`default_nettype none

module hcbp_ctrl (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [hcbp_pkg::FUNC_W-1:0]  func_i,
  input  wire logic                         hit_i,
  input  wire hcbp_pkg::dp_status_t         status_i,
  output hcbp_pkg::ctrl_cmd_t               cmd_o
);
  import hcbp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_PACK,
    S_FLUSH,
    S_MISS
  } state_e;

  state_e state_q, state_d;
  logic   ready_q, ready_d;
  logic   accept;

  assign accept     = in_valid_i && ready_q;
  assign in_ready_o = ready_q;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    ready_d = ready_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (func_i)
            FUNC_LOAD: begin
              cmd_o.tbl_load = 1'b1;
            end
            FUNC_ENCODE: begin
              ready_d = 1'b0;
              if (hit_i) begin
                cmd_o.tbl_read = 1'b1;
                state_d        = S_LOAD;
              end else begin
                state_d = S_MISS;
              end
            end
            FUNC_FLUSH: begin
              ready_d = 1'b0;
              state_d = S_FLUSH;
            end
            default: ;
          endcase
        end
      end
      S_LOAD: begin
        cmd_o.pend_load = 1'b1;
        state_d         = S_PACK;
      end
      S_PACK: begin
        if (status_i.rem_ge_need) begin
          if (status_i.slot_free) begin
            cmd_o.pack_step = 1'b1;
            if (status_i.rem_after_zero) begin
              state_d = S_IDLE;
              ready_d = 1'b1;
            end
          end
        end else begin
          cmd_o.pack_step = 1'b1;
          state_d         = S_IDLE;
          ready_d         = 1'b1;
        end
      end
      S_FLUSH: begin
        if (status_i.slot_free) begin
          cmd_o.flush_emit = 1'b1;
          state_d          = S_IDLE;
          ready_d          = 1'b1;
        end
      end
      S_MISS: begin
        if (status_i.slot_free) begin
          cmd_o.miss_emit = 1'b1;
          state_d         = S_IDLE;
          ready_d         = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
        ready_d = 1'b1;
      end
    endcase
  end

  // Hold state and the registered ready
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b1;
    end else begin
      state_q <= state_d;
      ready_q <= ready_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/huffman_code_bit_packer_unit.sv =====
// Top level of the prefix-code bit packer: stream ports, table, controller and datapath.
//
//  channel   direction  handshake                     payload
//  s_axis    in         s_axis_tvalid_i/tready_o      tuser func, tdata symbol/code/length
//  m_axis    out        m_axis_tvalid_o/tready_i      tdata byte/pad, tuser flags, tlast
//
// A load writes the table entry as it is accepted. An encode registers the table entry,
// copies it into the pending code, emits each completed byte and merges any leftover
// bits. A flush or a missing code waits for room in the output register. One byte per
// cycle through the single output register while it is not stalled. Reset clears the
// valid bits at once; no clearing pass. A stalled output holds the controller in place;
// input stays ready while a finished result waits, until the next encode or flush.
`default_nettype none

module huffman_code_bit_packer_unit #(
  parameter int unsigned MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF,
  parameter int unsigned SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // symbol [7:0], code_value [39:8], code_length [45:40], zero [47:46]
  input  wire logic [hcbp_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  // func [1:0]
  input  wire logic [hcbp_pkg::FUNC_W-1:0]       s_axis_tuser_i,
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // data_byte [7:0], pad_count [10:8], zero [15:11]
  output logic [hcbp_pkg::OUT_TDATA_W-1:0]       m_axis_tdata_o,
  // byte_present [0], missing_code [1]
  output logic [hcbp_pkg::OUT_TUSER_W-1:0]       m_axis_tuser_o,
  output logic                                   m_axis_tlast_o
);
  import hcbp_pkg::*;

  logic [SYM_W-1:0]  symbol;
  logic [CODE_W-1:0] code_value;
  logic [LEN_W-1:0]  code_length;
  ctrl_cmd_t         cmd;
  dp_status_t        status;
  logic              hit;
  logic [CODE_W-1:0] rd_code;
  logic [LEN_W-1:0]  rd_len;
  logic [BYTE_W-1:0] data_byte;
  logic              byte_present;
  logic [PAD_W-1:0]  pad_count;
  logic              missing_code;

  // Unpack the input item
  assign symbol      = s_axis_tdata_i[SYM_W-1:0];
  assign code_value  = s_axis_tdata_i[SYM_W+CODE_W-1:SYM_W];
  assign code_length = s_axis_tdata_i[SYM_W+CODE_W+LEN_W-1:SYM_W+CODE_W];

  hcbp_table #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_table (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .symbol_i      (symbol),
    .code_value_i  (code_value),
    .code_length_i (code_length),
    .hit_o         (hit),
    .rd_code_o     (rd_code),
    .rd_len_o      (rd_len)
  );

  hcbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .func_i     (s_axis_tuser_i),
    .hit_i      (hit),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  hcbp_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .rd_code_i      (rd_code),
    .rd_len_i       (rd_len),
    .status_o       (status),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .data_byte_o    (data_byte),
    .byte_present_o (byte_present),
    .pad_count_o    (pad_count),
    .missing_code_o (missing_code),
    .last_of_run_o  (m_axis_tlast_o)
  );

  // Pack the result item
  assign m_axis_tdata_o = {(OUT_TDATA_W - BYTE_W - PAD_W)'(0), pad_count, data_byte};
  assign m_axis_tuser_o = {missing_code, byte_present};

endmodule

`default_nettype wire
